@@ rtl/qte_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// qte_pkg
// Shared widths, constants, tables and types of the quaternion to Euler block.
// -----------------------------------------------------------------------------
package qte_pkg;

   localparam int QW         = 16;  // quaternion component, Q1.15
   localparam int ANG_W      = 16;  // binary angle out
   localparam int THR_W      = 32;  // singularity threshold, Q2.30
   localparam int PROD_W     = 32;  // one Q2.30 product
   localparam int SUM_W      = 34;  // doubled sum of products
   localparam int SQ_W       = 61;  // radicand of the cosine term
   localparam int SQRT_CELLS = 31;  // one result bit per cell
   localparam int CW         = 36;  // CORDIC x/y datapath
   localparam int ZW         = 32;  // CORDIC angle accumulator, 2^31 = pi

   localparam logic [THR_W-1:0]        THR_RESET   = 32'd1073739678;
   localparam logic signed [SUM_W-1:0] ONE_Q30     = 34'sd1073741824;
   localparam logic [SQ_W-1:0]         ONE_Q60     = 61'h1000000000000000;
   localparam logic [ZW-1:0]           Z_HALF_TURN = 32'h80000000;
   localparam logic [ZW-1:0]           ROUND_HALF  = 32'h00008000;
   localparam logic signed [ANG_W-1:0] ANG_QUARTER = 16'sd16384;

   // atan(2^-i), 2^31 = pi
   localparam logic [ZW-1:0] ATAN_TAB [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   typedef enum logic [1:0] {
      PITCH_ATAN,
      PITCH_UP,
      PITCH_DOWN
   } pitch_sel_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] roll_y;
      logic signed [SUM_W-1:0] roll_x;
      logic signed [SUM_W-1:0] yaw_y;
      logic signed [SUM_W-1:0] yaw_x;
      logic signed [SUM_W-1:0] s;
      pitch_sel_type           sel;
      logic                    lock;
   } side_type;

   typedef struct packed {
      pitch_sel_type sel;
      logic          lock;
   } flag_type;

   // Round the accumulator half up to a 16-bit binary angle, or give zero when flagged.
   function automatic logic [ANG_W-1:0] to_angle(input logic [ZW-1:0] z, input logic zero);
      logic [ZW-1:0] sum;
      sum = z + ROUND_HALF;
      return zero ? '0 : sum[ZW-1:ZW-ANG_W];
   endfunction

endpackage

@@ rtl/qte_req_if.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// qte_req_if
// Quaternion request channel: valid, ready and the four components.
// -----------------------------------------------------------------------------
interface qte_req_if;
   logic                        valid;
   logic                        ready;
   logic signed [qte_pkg::QW-1:0] quat_x;
   logic signed [qte_pkg::QW-1:0] quat_y;
   logic signed [qte_pkg::QW-1:0] quat_z;
   logic signed [qte_pkg::QW-1:0] quat_w;

   modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
   modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

@@ rtl/qte_rsp_if.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// qte_rsp_if
// Euler angle response channel: valid, ready, three angles and the lock flag.
// -----------------------------------------------------------------------------
interface qte_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [qte_pkg::ANG_W-1:0] roll_angle;
   logic signed [qte_pkg::ANG_W-1:0] pitch_angle;
   logic signed [qte_pkg::ANG_W-1:0] yaw_angle;
   logic                             gimbal_lock;

   modport source (output valid, roll_angle, pitch_angle, yaw_angle, gimbal_lock,
                   input ready);
   modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, gimbal_lock,
                   output ready);
endinterface

@@ rtl/qte_sqrt_cell.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// qte_sqrt_cell
// One restoring square root step: trial subtract of res + 4^K, one bit a cell.
// -----------------------------------------------------------------------------
module qte_sqrt_cell #(
   parameter int K = 0
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [qte_pkg::SQ_W-1:0]    v_in,
   input  logic [qte_pkg::SQ_W-1:0]    res_in,
   output logic [qte_pkg::SQ_W-1:0]    v_out,
   output logic [qte_pkg::SQ_W-1:0]    res_out
);
   import qte_pkg::*;

   localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * K);

   logic [SQ_W-1:0] trial;
   logic [SQ_W-1:0] v_ff,   v_in_nxt;
   logic [SQ_W-1:0] res_ff, res_in_nxt;

   always_comb begin
      trial = res_in + BIT;
      if (v_in >= trial) begin
         v_in_nxt   = v_in - trial;
         res_in_nxt = (res_in >> 1) + BIT;
      end else begin
         v_in_nxt   = v_in;
         res_in_nxt = res_in >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v_ff   <= v_in_nxt;
         res_ff <= res_in_nxt;
      end
   end

   assign v_out   = v_ff;
   assign res_out = res_ff;
endmodule

@@ rtl/qte_cordic_cell.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// qte_cordic_cell
// One vectoring CORDIC micro-rotation: drive y towards zero, track the angle.
// -----------------------------------------------------------------------------
module qte_cordic_cell #(
   parameter int STEP = 0
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [qte_pkg::CW-1:0] x_in,
   input  logic signed [qte_pkg::CW-1:0] y_in,
   input  logic [qte_pkg::ZW-1:0]        z_in,
   input  logic                          zero_in,
   output logic signed [qte_pkg::CW-1:0] x_out,
   output logic signed [qte_pkg::CW-1:0] y_out,
   output logic [qte_pkg::ZW-1:0]        z_out,
   output logic                          zero_out
);
   import qte_pkg::*;

   localparam logic [ZW-1:0] ANG = ATAN_TAB[STEP];

   logic signed [CW-1:0] dx, dy;
   logic signed [CW-1:0] x_ff, x_in_nxt;
   logic signed [CW-1:0] y_ff, y_in_nxt;
   logic [ZW-1:0]        z_ff, z_in_nxt;
   logic                 zero_ff;

   always_comb begin
      dx = x_in >>> STEP;
      dy = y_in >>> STEP;
      if (!y_in[CW-1]) begin
         x_in_nxt = x_in + dy;
         y_in_nxt = y_in - dx;
         z_in_nxt = z_in + ANG;
      end else begin
         x_in_nxt = x_in - dy;
         y_in_nxt = y_in + dx;
         z_in_nxt = z_in - ANG;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in_nxt;
         y_ff    <= y_in_nxt;
         z_ff    <= z_in_nxt;
         zero_ff <= zero_in;
      end
   end

   assign x_out    = x_ff;
   assign y_out    = y_ff;
   assign z_out    = z_ff;
   assign zero_out = zero_ff;
endmodule

@@ rtl/qte_cordic.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// qte_cordic
// atan2 as a row of CORDIC cells behind a half-plane pre-rotation stage.
// -----------------------------------------------------------------------------
module qte_cordic #(
   parameter int STEPS = 16
) (
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [qte_pkg::CW-1:0] y_in,
   input  logic signed [qte_pkg::CW-1:0] x_in,
   output logic [qte_pkg::ZW-1:0]        z_out,
   output logic                          zero_out
);
   import qte_pkg::*;

   logic signed [CW-1:0] xs [STEPS+1];
   logic signed [CW-1:0] ys [STEPS+1];
   logic [ZW-1:0]        zs [STEPS+1];
   logic                 zs_zero [STEPS+1];

   logic signed [CW-1:0] x_ff, y_ff;
   logic [ZW-1:0]        z_ff;
   logic                 zero_ff;

   // fold the left half-plane onto the right, flag the undefined origin
   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff <= (x_in == '0) && (y_in == '0);
         if (x_in[CW-1]) begin
            x_ff <= -x_in;
            y_ff <= -y_in;
            z_ff <= Z_HALF_TURN;
         end else begin
            x_ff <= x_in;
            y_ff <= y_in;
            z_ff <= '0;
         end
      end
   end

   assign xs[0]      = x_ff;
   assign ys[0]      = y_ff;
   assign zs[0]      = z_ff;
   assign zs_zero[0] = zero_ff;

   for (genvar i = 0; i < STEPS; i++) begin : g_cell
      qte_cordic_cell #(.STEP(i)) u_cell (
         .clock    (clock),
         .en       (en),
         .x_in     (xs[i]),
         .y_in     (ys[i]),
         .z_in     (zs[i]),
         .zero_in  (zs_zero[i]),
         .x_out    (xs[i+1]),
         .y_out    (ys[i+1]),
         .z_out    (zs[i+1]),
         .zero_out (zs_zero[i+1])
      );
   end

   assign z_out    = zs[STEPS];
   assign zero_out = zs_zero[STEPS];
endmodule

@@ rtl/quaternion_to_euler_zyx.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// quaternion_to_euler_zyx
// ZYX Euler angles (roll, pitch, yaw) from a Q1.15 quaternion, fully pipelined.
// -----------------------------------------------------------------------------
//  channel  | dir | payload                                         | handshake
//  ---------+-----+-------------------------------------------------+-----------
//  req_ch   | in  | quat_x, quat_y, quat_z, quat_w                  | valid/ready
//  rsp_ch   | out | roll_angle, pitch_angle, yaw_angle, gimbal_lock | valid/ready
//  csr_*    | in  | singularity_threshold (Q2.30)                   | write enable
//
//  Throughput: one quaternion per cycle while the output is not stalled.
//  Stages: products, sums, square, radicand, a row of 31 square root cells,
//  then three parallel CORDIC rows of CORDIC_STEPS cells with a pre-rotation
//  stage, and the output register.
//  Reset clears the stage valid bits and loads the default threshold.
//  A result not taken freezes the whole row; ready drops only in that case.
// -----------------------------------------------------------------------------
module quaternion_to_euler_zyx #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [qte_pkg::THR_W-1:0]   csr_wr_data,
   qte_req_if.sink                     req_ch,
   qte_rsp_if.source                   rsp_ch
);
   import qte_pkg::*;

   localparam int NV = SQRT_CELLS + CORDIC_STEPS + 6;

   // --- control ---------------------------------------------------------------
   logic            adv;
   logic [NV-1:0]   vld_ff;
   logic [THR_W-1:0] thr_ff;

   // advance the row unless the output holds an untaken transaction
   assign adv          = !vld_ff[NV-1] || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NV-2:0], req_ch.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   // --- stage 1: the ten Q2.30 products ----------------------------------------
   logic signed [PROD_W-1:0] xx_ff, yy_ff, zz_ff, ww_ff;
   logic signed [PROD_W-1:0] wy_ff, xz_ff, yz_ff, wx_ff, xy_ff, wz_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         xx_ff <= PROD_W'(req_ch.quat_x) * PROD_W'(req_ch.quat_x);
         yy_ff <= PROD_W'(req_ch.quat_y) * PROD_W'(req_ch.quat_y);
         zz_ff <= PROD_W'(req_ch.quat_z) * PROD_W'(req_ch.quat_z);
         ww_ff <= PROD_W'(req_ch.quat_w) * PROD_W'(req_ch.quat_w);
         wy_ff <= PROD_W'(req_ch.quat_w) * PROD_W'(req_ch.quat_y);
         xz_ff <= PROD_W'(req_ch.quat_x) * PROD_W'(req_ch.quat_z);
         yz_ff <= PROD_W'(req_ch.quat_y) * PROD_W'(req_ch.quat_z);
         wx_ff <= PROD_W'(req_ch.quat_w) * PROD_W'(req_ch.quat_x);
         xy_ff <= PROD_W'(req_ch.quat_x) * PROD_W'(req_ch.quat_y);
         wz_ff <= PROD_W'(req_ch.quat_w) * PROD_W'(req_ch.quat_z);
      end
   end

   // --- stage 2: atan2 arguments and the pitch decision -----------------------
   logic signed [SUM_W-1:0] s_in;
   logic [SUM_W-2:0]        mag_in;
   pitch_sel_type           sel_in;
   logic                    lock_in;
   side_type                side2_in, side2_ff;

   always_comb begin
      s_in   = (SUM_W'(wy_ff) - SUM_W'(xz_ff)) <<< 1;
      mag_in = s_in[SUM_W-1] ? (SUM_W-1)'(-s_in) : s_in[SUM_W-2:0];
      // clamp beyond the threshold, saturate at one, otherwise run the atan2
      lock_in = mag_in > {1'b0, thr_ff};
      priority if (lock_in) begin
         sel_in = s_in[SUM_W-1] ? PITCH_DOWN : PITCH_UP;
      end else if (s_in >= ONE_Q30) begin
         sel_in = PITCH_UP;
      end else if (s_in <= -ONE_Q30) begin
         sel_in = PITCH_DOWN;
      end else begin
         sel_in = PITCH_ATAN;
      end
      side2_in.roll_y = (SUM_W'(yz_ff) + SUM_W'(wx_ff)) <<< 1;
      side2_in.roll_x = SUM_W'(ww_ff) - SUM_W'(xx_ff) - SUM_W'(yy_ff) + SUM_W'(zz_ff);
      side2_in.yaw_y  = (SUM_W'(xy_ff) + SUM_W'(wz_ff)) <<< 1;
      side2_in.yaw_x  = SUM_W'(ww_ff) + SUM_W'(xx_ff) - SUM_W'(yy_ff) - SUM_W'(zz_ff);
      side2_in.s      = s_in;
      side2_in.sel    = sel_in;
      side2_in.lock   = lock_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side2_ff <= side2_in;
      end
   end

   // --- stages 3 and 4: s squared, then the radicand 1 - s^2 in Q60 -----------
   // only the in-range case reaches the output, so s fits 31 bits there
   logic signed [30:0]     s_lo;
   logic signed [SQ_W:0]   sq_ff;
   logic [SQ_W-1:0]        rem_ff;
   side_type               side_ff [SQRT_CELLS+2];

   assign s_lo = $signed(side2_ff.s[30:0]);

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_ff      <= s_lo * s_lo;
         side_ff[0] <= side2_ff;
         rem_ff     <= ONE_Q60 - sq_ff[SQ_W-1:0];
         side_ff[1] <= side_ff[0];
      end
   end

   // --- square root row, side data travels alongside --------------------------
   logic [SQ_W-1:0] sv [SQRT_CELLS+1];
   logic [SQ_W-1:0] sr [SQRT_CELLS+1];

   assign sv[0] = rem_ff;
   assign sr[0] = '0;

   for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
      qte_sqrt_cell #(.K(SQRT_CELLS - 1 - j)) u_cell (
         .clock   (clock),
         .en      (adv),
         .v_in    (sv[j]),
         .res_in  (sr[j]),
         .v_out   (sv[j+1]),
         .res_out (sr[j+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < SQRT_CELLS; j++) begin
            side_ff[j+2] <= side_ff[j+1];
         end
      end
   end

   // --- three CORDIC rows in lock step ----------------------------------------
   side_type             side_q;
   logic signed [CW-1:0] cos_x;
   logic [ZW-1:0]        z_roll, z_pitch, z_yaw;
   logic                 zero_roll, zero_pitch, zero_yaw;
   flag_type             flg_ff [CORDIC_STEPS+1];

   assign side_q = side_ff[SQRT_CELLS+1];
   assign cos_x  = $signed({{(CW-SQRT_CELLS){1'b0}}, sr[SQRT_CELLS][SQRT_CELLS-1:0]});

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
      .clock    (clock),
      .en       (adv),
      .y_in     (CW'(side_q.roll_y)),
      .x_in     (CW'(side_q.roll_x)),
      .z_out    (z_roll),
      .zero_out (zero_roll)
   );

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
      .clock    (clock),
      .en       (adv),
      .y_in     (CW'(side_q.s)),
      .x_in     (cos_x),
      .z_out    (z_pitch),
      .zero_out (zero_pitch)
   );

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
      .clock    (clock),
      .en       (adv),
      .y_in     (CW'(side_q.yaw_y)),
      .x_in     (CW'(side_q.yaw_x)),
      .z_out    (z_yaw),
      .zero_out (zero_yaw)
   );

   // hold the pitch decision level with the CORDIC rows
   always_ff @(posedge clock) begin
      if (adv) begin
         flg_ff[0].sel  <= side_q.sel;
         flg_ff[0].lock <= side_q.lock;
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            flg_ff[i+1] <= flg_ff[i];
         end
      end
   end

   // --- output register --------------------------------------------------------
   logic signed [ANG_W-1:0] pitch_in;
   logic signed [ANG_W-1:0] roll_ff, pitch_ff, yaw_ff;
   logic                    lock_ff;

   always_comb begin
      unique case (flg_ff[CORDIC_STEPS].sel)
         PITCH_UP:   pitch_in = ANG_QUARTER;
         PITCH_DOWN: pitch_in = -ANG_QUARTER;
         PITCH_ATAN: pitch_in = $signed(to_angle(z_pitch, zero_pitch));
         default:    pitch_in = $signed(to_angle(z_pitch, zero_pitch));
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         roll_ff  <= $signed(to_angle(z_roll, zero_roll));
         pitch_ff <= pitch_in;
         yaw_ff   <= $signed(to_angle(z_yaw, zero_yaw));
         lock_ff  <= flg_ff[CORDIC_STEPS].lock;
      end
   end

   assign rsp_ch.valid       = vld_ff[NV-1];
   assign rsp_ch.roll_angle  = roll_ff;
   assign rsp_ch.pitch_angle = pitch_ff;
   assign rsp_ch.yaw_angle   = yaw_ff;
   assign rsp_ch.gimbal_lock = lock_ff;

   // --- assertions -------------------------------------------------------------
   // a clamped pitch sits exactly on a pole
   a_lock_pole: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.gimbal_lock) |->
      (rsp_ch.pitch_angle == ANG_QUARTER || rsp_ch.pitch_angle == -ANG_QUARTER))
      else $error("gimbal lock without a pole pitch");

   // an accepted transaction enters the first stage
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> vld_ff[0])
      else $error("accepted transaction lost at entry");

   // the row only stalls behind an untaken result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> (rsp_ch.valid && !rsp_ch.ready))
      else $error("ready dropped without a stalled result");

endmodule

@@ sim/quaternion_to_euler_zyx_tb.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// quaternion_to_euler_zyx_tb
// Streams quaternions through the Euler angle block under random idling on
// both handshakes and checks every transaction against a bit-exact predictor
// of the fixed point arithmetic, over several singularity thresholds.
// -----------------------------------------------------------------------------
module quaternion_to_euler_zyx_tb;
   import qte_pkg::*;

   localparam int STEPS     = 16;
   localparam int LATENCY   = STEPS + 37;
   localparam int MAX_CYCLE = 400000;

   typedef struct packed {
      logic signed [QW-1:0] qx, qy, qz, qw;
   } quat_type;

   typedef struct packed {
      logic [ANG_W-1:0] roll, pitch, yaw;
      logic             lock;
   } euler_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [THR_W-1:0] csr_wr_data = '0;

   qte_req_if req_ch ();
   qte_rsp_if rsp_ch ();

   quaternion_to_euler_zyx #(.CORDIC_STEPS(STEPS)) dut (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .req_ch(req_ch), .rsp_ch(rsp_ch)
   );

   always #5 clock = ~clock;

   quat_type  pending_quats[$];
   euler_type expected_angles[$];
   logic [THR_W-1:0] threshold_model;
   int  failures = 0;
   int  cycle = 0;
   bit  quiet = 1'b0;    // no idling in the closing part
   int  hold_off = 0;    // long receiver stall, counted by the monitor
   int  send_gap = 0, recv_gap = 0;

   // Arithmetic shift right rounding towards minus infinity.
   function automatic longint asr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res = 0, b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic logic [ZW-1:0] vector_angle(longint y, longint x);
      logic [ZW-1:0] z = '0;
      longint dx, dy;
      if (x == 0 && y == 0) return '0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = Z_HALF_TURN;
      end
      for (int i = 0; i < STEPS; i++) begin
         dx = asr(x, i);
         dy = asr(y, i);
         if (y >= 0) begin
            x += dy; y -= dx; z += ATAN_TAB[i];
         end else begin
            x -= dy; y += dx; z -= ATAN_TAB[i];
         end
      end
      return z;
   endfunction

   function automatic logic [ANG_W-1:0] round_angle(logic [ZW-1:0] z);
      logic [ZW-1:0] t = z + ROUND_HALF;
      return t[ZW-1:ZW-ANG_W];
   endfunction

   function automatic euler_type euler_of(quat_type q);
      euler_type e;
      longint x = q.qx, y = q.qy, z = q.qz, w = q.qw;
      longint s = 2 * (w * y - x * z);
      longint unsigned mag = (s < 0) ? -s : s;
      longint one = 64'sd1 << 30;
      e.lock = 1'b0;
      if (mag > threshold_model) begin
         e.lock  = 1'b1;
         e.pitch = (s < 0) ? -ANG_QUARTER : ANG_QUARTER;
      end else if (s >= one) begin
         e.pitch = ANG_QUARTER;
      end else if (s <= -one) begin
         e.pitch = -ANG_QUARTER;
      end else begin
         e.pitch = round_angle(vector_angle(s, longint'(int_sqrt(
            longint'(one * one) - s * s))));
      end
      e.roll = round_angle(vector_angle(2 * (y * z + w * x), w*w - x*x - y*y + z*z));
      e.yaw  = round_angle(vector_angle(2 * (x * y + w * z), w*w + x*x - y*y - z*z));
      return e;
   endfunction

   // Driver: pop the queue, hold the transaction until it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.quat_x <= '0; req_ch.quat_y <= '0;
         req_ch.quat_z <= '0; req_ch.quat_w <= '0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) expected_angles.push_back(euler_of({req_ch.quat_x,
            req_ch.quat_y, req_ch.quat_z, req_ch.quat_w}));
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (pending_quats.size() > 0 && !csr_wr_en) begin
            automatic quat_type q = pending_quats.pop_front();
            req_ch.valid <= 1'b1;
            {req_ch.quat_x, req_ch.quat_y, req_ch.quat_z, req_ch.quat_w} <= q;
            if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 17);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Monitor: compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            automatic euler_type got = {rsp_ch.roll_angle, rsp_ch.pitch_angle,
                                        rsp_ch.yaw_angle, rsp_ch.gimbal_lock};
            if (expected_angles.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               failures++;
            end else begin
               automatic euler_type exp_e = expected_angles.pop_front();
               if (got.roll !== exp_e.roll)
                  $display("%0t: roll expected %0d actual %0d", $time,
                           $signed(exp_e.roll), $signed(got.roll));
               if (got.pitch !== exp_e.pitch)
                  $display("%0t: pitch expected %0d actual %0d", $time,
                           $signed(exp_e.pitch), $signed(got.pitch));
               if (got.yaw !== exp_e.yaw)
                  $display("%0t: yaw expected %0d actual %0d", $time,
                           $signed(exp_e.yaw), $signed(got.yaw));
               if (got.lock !== exp_e.lock)
                  $display("%0t: lock expected %b actual %b", $time,
                           exp_e.lock, got.lock);
               if (got !== exp_e) failures++;
            end
         end
         // A long hold-off takes priority, then random stall bursts.
         if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            rsp_ch.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!quiet && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 17);
         end
      end
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      if (cycle > MAX_CYCLE) begin
         $display("quaternion_to_euler_zyx verification failed");
         $finish;
      end
   end

   function automatic quat_type random_quat();
      quat_type q;
      case ($urandom_range(0, 3))
         0: q = {$urandom, $urandom};
         1: begin
            // near unit length: one large component, small others
            q = {16'($urandom_range(0, 4095) - 2048), 16'($urandom_range(0, 4095) - 2048),
                 16'($urandom_range(0, 4095) - 2048), 16'($urandom_range(0, 4095) - 2048)};
            case ($urandom_range(0, 3))
               0: q.qx = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32767;
               1: q.qy = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32767;
               2: q.qz = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32767;
               default: q.qw = $urandom_range(0, 1) ? 16'sd32767 : -16'sd32767;
            endcase
         end
         2: begin
            // close to gimbal lock: w = y or w = -y at about 1/sqrt2
            q.qw = 16'($urandom_range(23000, 23400));
            q.qy = $urandom_range(0, 1) ? q.qw : -q.qw;
            q.qx = 16'($urandom_range(0, 63) - 32);
            q.qz = 16'($urandom_range(0, 63) - 32);
         end
         default: q = {16'($urandom_range(0, 32767) - 16384),
                       16'($urandom_range(0, 32767) - 16384),
                       16'($urandom_range(0, 32767) - 16384),
                       16'($urandom_range(0, 32767) - 16384)};
      endcase
      return q;
   endfunction

   // Write the threshold once the pipe has drained.
   task automatic set_threshold(logic [THR_W-1:0] value);
      while (pending_quats.size() > 0 || req_ch.valid || expected_angles.size() > 0)
         @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      threshold_model = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [THR_W-1:0] settings [5];
      settings = '{32'd0, 32'hFFFFFFFF, 32'h40000000, 32'h80000000, 32'd536870912};
      threshold_model = THR_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, identity, exact gimbal lock, both atan2 arguments zero.
      pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
      pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd32767});
      pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, -16'sd32768});
      pending_quats.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
      pending_quats.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
      pending_quats.push_back('{16'sd0, 16'sd23170, 16'sd0, 16'sd23170});
      pending_quats.push_back('{16'sd0, -16'sd23170, 16'sd0, 16'sd23170});
      pending_quats.push_back('{16'sd23170, 16'sd0, 16'sd23170, 16'sd0});
      pending_quats.push_back('{-16'sd23170, 16'sd0, 16'sd23170, 16'sd0});
      pending_quats.push_back('{16'sd32767, 16'sd0, 16'sd0, 16'sd0});
      pending_quats.push_back('{16'sd0, 16'sd0, 16'sd32767, 16'sd0});
      pending_quats.push_back('{16'sd0, 16'sd0, -16'sd32768, 16'sd1});
      pending_quats.push_back('{16'sd0, -16'sd32768, 16'sd0, 16'sd0});
      pending_quats.push_back('{16'sd1, -16'sd1, 16'sd1, -16'sd1});
      // Pressure: stall the receiver long enough for the pipe to fill.
      hold_off = 300;
      repeat (40) pending_quats.push_back(random_quat());

      foreach (settings[k]) begin
         set_threshold(settings[k]);
         repeat (60) pending_quats.push_back(random_quat());
      end
      set_threshold(THR_RESET);
      repeat (100) pending_quats.push_back(random_quat());
      while (pending_quats.size() > 0) @(posedge clock);
      // Closing part: no idling.
      quiet = 1'b1;
      repeat (40) pending_quats.push_back(random_quat());

      while (pending_quats.size() > 0 || req_ch.valid || expected_angles.size() > 0)
         @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      if (failures == 0)
         $display("quaternion_to_euler_zyx verification clean");
      else
         $display("quaternion_to_euler_zyx verification failed");
      $finish;
   end

endmodule
